// ===== sv/icmp_erc_pkg.sv =====
// Package for the ICMP echo-reply checker: sizes, limits, verdict codes
// and the result record shared by the core, the output buffer and the top level.
// No dependencies.
package icmp_erc_pkg;

   localparam int unsigned MaxPacketBytes  = 65535;
   localparam int unsigned IcmpHeaderBytes = 8;
   localparam int unsigned MinIpBytes      = 20;
   localparam int unsigned MinHdrWords     = 5;
   localparam int unsigned CountWidth      = 16;

   localparam logic [7:0]  EchoReplyType   = 8'd0;
   localparam logic [7:0]  GoodCode        = 8'd0;
   localparam logic [15:0] SumGood         = 16'hFFFF;

   localparam int unsigned CsrAddrWidth    = 3;
   localparam logic [0:0]  RegExpectedId   = 1'b0;

   typedef enum logic [2:0] {
      VerdictOk       = 3'd0,
      VerdictTooSmall = 3'd1,
      VerdictBadHlen  = 3'd2,
      VerdictTrunc    = 3'd3,
      VerdictType     = 3'd4,
      VerdictCode     = 3'd5,
      VerdictId       = 3'd6,
      VerdictChecksum = 3'd7
   } verdict_type;

   typedef struct packed {
      logic [7:0]  icmp_code;
      logic [7:0]  icmp_type;
      verdict_type verdict;
   } result_type;

   // Ones'-complement add of two 16-bit words with end-around carry.
   function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

endpackage

// ===== sv/icmp_erc_csr.sv =====
// Configuration register block of the ICMP echo-reply checker: APB-style
// write and read of the expected identifier. Uses icmp_erc_pkg.
module icmp_erc_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [icmp_erc_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [31:0]                           csr_pwdata,
   output logic [31:0]                           csr_prdata,
   output logic                                  csr_pready,
   output logic [15:0]                           expected_id
);
   import icmp_erc_pkg::*;

   logic [15:0] expected_id_ff;
   logic [15:0] expected_id_in;
   logic        reg_sel;

   assign csr_pready = 1'b1;
   assign reg_sel    = (csr_paddr[CsrAddrWidth-1:2] == RegExpectedId);

   always_comb begin
      expected_id_in = expected_id_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && reg_sel) begin
         expected_id_in = csr_pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_id_ff <= '0;
      end else begin
         expected_id_ff <= expected_id_in;
      end
   end

   assign csr_prdata  = reg_sel ? {16'd0, expected_id_ff} : 32'd0;
   assign expected_id = expected_id_ff;

endmodule

// ===== sv/icmp_erc_core.sv =====
// Per-packet state and verdict logic of the ICMP echo-reply checker: header
// length, ICMP field capture, running checksum and the final checks.
// Uses icmp_erc_pkg.
module icmp_erc_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     fire,
   input  logic [7:0]               data_byte,
   input  logic                     last_byte,
   input  logic [15:0]              expected_id,
   output logic                     push,
   output icmp_erc_pkg::result_type result
);
   import icmp_erc_pkg::*;

   logic [CountWidth-1:0] byte_count_ff, byte_count_in;
   logic [3:0]            header_words_ff, header_words_in;
   logic [7:0]            seen_type_ff, seen_type_in;
   logic [7:0]            seen_code_ff, seen_code_in;
   logic [15:0]           seen_id_ff, seen_id_in;
   logic [15:0]           sum_ff, sum_in;
   logic [7:0]            pending_ff, pending_in;

   logic [CountWidth-1:0] pos;
   logic                  taken;
   logic [3:0]            hw_n;
   logic [5:0]            start;
   logic                  in_icmp;
   logic [CountWidth-1:0] off;
   logic [7:0]            type_n, code_n, pend_n;
   logic [15:0]           id_n, sum_n, sum_chk, pad_word;
   logic [CountWidth-1:0] len;
   logic [CountWidth:0]   need_len;
   verdict_type           verdict;

   always_comb begin
      pos     = byte_count_ff;
      taken   = ({1'b0, pos} < (CountWidth+1)'(MaxPacketBytes));
      hw_n    = (taken && pos == '0) ? data_byte[3:0] : header_words_ff;
      start   = {hw_n, 2'b00};
      in_icmp = taken && (pos >= CountWidth'(start));
      off     = pos - CountWidth'(start);
      len     = taken ? pos + CountWidth'(1) : pos;

      type_n = seen_type_ff;
      code_n = seen_code_ff;
      id_n   = seen_id_ff;
      pend_n = pending_ff;
      sum_n  = sum_ff;
      if (in_icmp) begin
         if (off == CountWidth'(0)) type_n = data_byte;
         if (off == CountWidth'(1)) code_n = data_byte;
         if (off == CountWidth'(4)) id_n[15:8] = data_byte;
         if (off == CountWidth'(5)) id_n[7:0] = data_byte;
         // The ICMP start is a multiple of four, so the word phase follows pos.
         if (!pos[0]) begin
            pend_n = data_byte;
         end else begin
            sum_n = ones_add(sum_ff, {pending_ff, data_byte});
         end
      end

      // The final word, completed or padded with zero, is folded in for the check.
      if (in_icmp) begin
         pad_word = pos[0] ? {pending_ff, data_byte} : {data_byte, 8'h00};
      end else begin
         pad_word = len[0] ? {pending_ff, 8'h00} : 16'h0000;
      end
      sum_chk  = ones_add(sum_ff, pad_word);
      need_len = (CountWidth+1)'(start) + (CountWidth+1)'(IcmpHeaderBytes);

      if (len < CountWidth'(MinIpBytes)) begin
         verdict = VerdictTooSmall;
      end else if (hw_n < 4'(MinHdrWords)) begin
         verdict = VerdictBadHlen;
      end else if ({1'b0, len} < need_len) begin
         verdict = VerdictTrunc;
      end else if (type_n != EchoReplyType) begin
         verdict = VerdictType;
      end else if (code_n != GoodCode) begin
         verdict = VerdictCode;
      end else if (id_n != expected_id) begin
         verdict = VerdictId;
      end else if (sum_chk != SumGood) begin
         verdict = VerdictChecksum;
      end else begin
         verdict = VerdictOk;
      end

      byte_count_in   = byte_count_ff;
      header_words_in = header_words_ff;
      seen_type_in    = seen_type_ff;
      seen_code_in    = seen_code_ff;
      seen_id_in      = seen_id_ff;
      sum_in          = sum_ff;
      pending_in      = pending_ff;
      if (fire) begin
         if (last_byte) begin
            byte_count_in   = '0;
            header_words_in = '0;
            seen_type_in    = '0;
            seen_code_in    = '0;
            seen_id_in      = '0;
            sum_in          = '0;
            pending_in      = '0;
         end else begin
            byte_count_in   = len;
            header_words_in = hw_n;
            seen_type_in    = type_n;
            seen_code_in    = code_n;
            seen_id_in      = id_n;
            sum_in          = sum_n;
            pending_in      = pend_n;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff   <= '0;
         header_words_ff <= '0;
         seen_type_ff    <= '0;
         seen_code_ff    <= '0;
         seen_id_ff      <= '0;
         sum_ff          <= '0;
         pending_ff      <= '0;
      end else begin
         byte_count_ff   <= byte_count_in;
         header_words_ff <= header_words_in;
         seen_type_ff    <= seen_type_in;
         seen_code_ff    <= seen_code_in;
         seen_id_ff      <= seen_id_in;
         sum_ff          <= sum_in;
         pending_ff      <= pending_in;
      end
   end

   assign push             = fire && last_byte;
   assign result.verdict   = verdict;
   assign result.icmp_type = type_n;
   assign result.icmp_code = code_n;

endmodule

// ===== sv/icmp_erc_obuf.sv =====
// Two-entry output buffer of the ICMP echo-reply checker: holds verdicts
// until the response side takes them. Uses icmp_erc_pkg.
module icmp_erc_obuf (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  icmp_erc_pkg::result_type push_data,
   output logic                     space,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output icmp_erc_pkg::result_type rsp_data
);
   import icmp_erc_pkg::*;

   result_type entry_ff [2];
   logic [1:0] count_ff, count_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       pop;

   assign rsp_tvalid = (count_ff != 2'd0);
   assign space      = (count_ff != 2'd2);
   assign rsp_data   = entry_ff[rd_ptr_ff];
   assign pop        = rsp_tvalid && rsp_tready;

   always_comb begin
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/icmp_echo_reply_check.sv =====
// ICMP echo-reply checker, top level: input register, configuration port,
// packet core and output buffer. Uses icmp_erc_pkg and the icmp_erc_* modules.
//
// The block takes one IPv4 packet byte per cycle on the request channel, with
// tlast on the final byte, and returns one verdict per packet on the response
// channel. A request is registered on acceptance and then checked; its verdict
// is offered in the cycle after the check. The sustained rate is one byte per
// clock, set by the update of the running checksum and capture state; a final
// byte waits in the input register only while both entries of the output buffer
// are full. Write expected_id only while no packet is open.
module icmp_echo_reply_check (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [7:0]                            req_tdata,  // [7:0] data_byte
   input  logic                                  req_tlast,  // last_byte
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [2:0] verdict, [10:3] icmp_type, [18:11] icmp_code, [23:19] zero
   output logic [23:0]                           rsp_tdata,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [icmp_erc_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [31:0]                           csr_pwdata,
   output logic [31:0]                           csr_prdata,
   output logic                                  csr_pready
);
   import icmp_erc_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_data_ff, in_data_in;
   logic       in_last_ff, in_last_in;
   logic       fire;
   logic       req_fire;
   logic       push;
   logic       space;
   logic [15:0] expected_id;
   result_type result;
   result_type rsp_data;

   icmp_erc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .expected_id (expected_id)
   );

   assign fire       = in_valid_ff && (!in_last_ff || space);
   assign req_tready = !in_valid_ff || fire;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      in_last_in  = in_last_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_data_in  = req_tdata;
         in_last_in  = req_tlast;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
      in_last_ff <= in_last_in;
   end

   icmp_erc_core u_core (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .data_byte   (in_data_ff),
      .last_byte   (in_last_ff),
      .expected_id (expected_id),
      .push        (push),
      .result      (result)
   );

   icmp_erc_obuf u_obuf (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (result),
      .space      (space),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_data)
   );

   assign rsp_tdata = {5'd0, rsp_data};

`ifndef SYNTHESIS
   a_stall_holds_item: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> in_valid_ff)
      else $error("request stalled with an empty input register");

   a_verdict_offered: assert property (@(posedge clock) disable iff (reset)
      push |=> rsp_tvalid)
      else $error("verdict was not offered after a final byte");

   a_last_needs_room: assert property (@(posedge clock) disable iff (reset)
      push |-> space)
      else $error("verdict pushed into a full output buffer");

   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite && csr_paddr[CsrAddrWidth-1:2] == RegExpectedId)
      |=> expected_id == $past(csr_pwdata[15:0]))
      else $error("expected_id write was lost");
`endif

endmodule

// ===== dv/icmp_echo_reply_check_monitor.sv =====
// Verdict monitor for the ICMP echo-reply checker: follows the request, response
// and register channels, predicts one verdict per packet and compares responses.
// Depends on icmp_erc_pkg.
module icmp_echo_reply_check_monitor (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   input  logic                                  req_tready,
   input  logic [7:0]                            req_tdata,  // [7:0] data_byte
   input  logic                                  req_tlast,  // last_byte
   input  logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [2:0] verdict, [10:3] icmp_type, [18:11] icmp_code, [23:19] zero
   input  logic [23:0]                           rsp_tdata,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [icmp_erc_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [31:0]                           csr_pwdata,
   input  logic                                  csr_pready,
   output int unsigned                           fault_count,
   output int unsigned                           verdicts_checked,
   output int unsigned                           results_open
);
   import icmp_erc_pkg::*;

   localparam logic [CsrAddrWidth-1:0] IdRegAddr = CsrAddrWidth'(RegExpectedId) << 2;

   logic [15:0] want_id;
   logic [15:0] bytes_taken;
   logic [3:0]  hdr_words;
   logic [7:0]  got_type;
   logic [7:0]  got_code;
   logic [15:0] got_id;
   logic [15:0] run_sum;
   logic [7:0]  high_half;
   result_type  verdicts_due[$];

   function automatic logic [15:0] wrap_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] t;
      t = {1'b0, a} + {1'b0, b};
      return t[15:0] + 16'(t[16]);
   endfunction

   task automatic clear_packet();
      bytes_taken = 16'd0;
      hdr_words = 4'd0;
      got_type = 8'd0;
      got_code = 8'd0;
      got_id = 16'd0;
      run_sum = 16'd0;
      high_half = 8'd0;
   endtask

   // Bytes past the count limit are dropped; byte 0 always sets the header
   // length, and the ICMP part starts at four bytes per header word.
   task automatic absorb_byte(input logic [7:0] b);
      int unsigned start;
      int unsigned off;
      if (bytes_taken >= MaxPacketBytes) return;
      if (bytes_taken == 16'd0) hdr_words = b[3:0];
      start = 4 * hdr_words;
      if (bytes_taken >= start) begin
         off = bytes_taken - start;
         case (off)
            0: got_type = b;
            1: got_code = b;
            4: got_id[15:8] = b;
            5: got_id[7:0] = b;
            default: ;
         endcase
         if (off[0] == 1'b0) begin
            high_half = b;
         end else begin
            run_sum = wrap_add(run_sum, {high_half, b});
         end
      end
      bytes_taken = bytes_taken + 16'd1;
   endtask

   function automatic verdict_type packet_verdict();
      int unsigned start;
      logic [15:0] total;
      start = 4 * hdr_words;
      total = run_sum;
      if (bytes_taken < MinIpBytes) return VerdictTooSmall;
      if (hdr_words < MinHdrWords) return VerdictBadHlen;
      if (bytes_taken < start + IcmpHeaderBytes) return VerdictTrunc;
      if (got_type != EchoReplyType) return VerdictType;
      if (got_code != GoodCode) return VerdictCode;
      if (got_id != want_id) return VerdictId;
      if (((bytes_taken - start) & 1) != 0) total = wrap_add(total, {high_half, 8'h00});
      return (total == SumGood) ? VerdictOk : VerdictChecksum;
   endfunction

   always @(posedge clock) begin
      result_type want;
      result_type fresh;
      if (reset) begin
         clear_packet();
         want_id = 16'd0;
         verdicts_due.delete();
         fault_count = 0;
         verdicts_checked = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (verdicts_due.size() == 0) begin
               fault_count++;
               $display("%0t: expected no response, got %h", $time, rsp_tdata);
            end else begin
               want = verdicts_due.pop_front();
               verdicts_checked++;
               if (rsp_tdata[2:0] != want.verdict || rsp_tdata[10:3] != want.icmp_type ||
                   rsp_tdata[18:11] != want.icmp_code || rsp_tdata[23:19] != 5'd0) begin
                  fault_count++;
                  $display("%0t: expected verdict %0d type %h code %h pad 00, got %0d %h %h %h",
                           $time, want.verdict, want.icmp_type, want.icmp_code,
                           rsp_tdata[2:0], rsp_tdata[10:3], rsp_tdata[18:11],
                           rsp_tdata[23:19]);
               end
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == IdRegAddr)
            want_id = csr_pwdata[15:0];
         if (req_tvalid && req_tready) begin
            absorb_byte(req_tdata);
            if (req_tlast) begin
               fresh.verdict = packet_verdict();
               fresh.icmp_type = got_type;
               fresh.icmp_code = got_code;
               verdicts_due.push_back(fresh);
               clear_packet();
            end
         end
      end
      results_open = verdicts_due.size();
   end

endmodule

// ===== dv/icmp_echo_reply_check_tb.sv =====
// Testbench top for the ICMP echo-reply checker: clock, reset, packet and register
// stimulus, response back-pressure and the final verdict.
// Depends on icmp_erc_pkg, icmp_echo_reply_check and icmp_echo_reply_check_monitor.
module icmp_echo_reply_check_tb;
   import icmp_erc_pkg::*;

   localparam int unsigned WatchdogLimit = 4000;
   localparam int unsigned HoldCycles    = 300;
   localparam logic [CsrAddrWidth-1:0] IdRegAddr = CsrAddrWidth'(RegExpectedId) << 2;

   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    req_tvalid  = 1'b0;
   logic                    req_tready;
   logic [7:0]              req_tdata   = 8'd0;
   logic                    req_tlast   = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready  = 1'b0;
   logic [23:0]             rsp_tdata;
   logic                    csr_psel    = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite  = 1'b0;
   logic [CsrAddrWidth-1:0] csr_paddr   = '0;
   logic [31:0]             csr_pwdata  = 32'd0;
   logic [31:0]             csr_prdata;
   logic                    csr_pready;

   int unsigned fault_count;
   int unsigned verdicts_checked;
   int unsigned results_open;

   int unsigned send_idle_pct = 36;
   int unsigned recv_idle_pct = 47;
   logic        hold_go       = 1'b0;
   logic        hold_done     = 1'b0;
   int unsigned hold_left     = 0;
   int unsigned quiet_cycles  = 0;
   int unsigned bytes_sent    = 0;
   int unsigned packets_sent  = 0;
   logic [15:0] cur_id        = 16'h0000;
   logic [7:0]  frame[$];

   always #6 clock = ~clock;

   icmp_echo_reply_check dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   icmp_echo_reply_check_monitor verdict_mon (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_pready      (csr_pready),
      .fault_count     (fault_count),
      .verdicts_checked(verdicts_checked),
      .results_open    (results_open)
   );

   // A single long stall lets the output buffer fill and push back on requests.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_go && !hold_done) begin
         hold_left <= HoldCycles;
         hold_done <= 1'b1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
         $display("%0t: no transfer for %0d cycles, stopping", $time, WatchdogLimit);
         $display("** icmp_echo_reply_check: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_frame();
      foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1);
      packets_sent++;
   endtask

   task automatic trim_frame(input int unsigned n);
      while (frame.size() > n) frame.delete(frame.size() - 1);
   endtask

   function automatic logic [15:0] ones_total(input int from);
      logic [16:0] t;
      logic [15:0] s;
      logic [15:0] w;
      s = 16'h0000;
      for (int i = from; i < frame.size(); i += 2) begin
         w = {frame[i], (i + 1 < frame.size()) ? frame[i + 1] : 8'h00};
         t = {1'b0, s} + {1'b0, w};
         s = t[15:0] + 16'(t[16]);
      end
      return s;
   endfunction

   task automatic seal_checksum(input int at);
      logic [15:0] s;
      frame[at + 2] = 8'h00;
      frame[at + 3] = 8'h00;
      s = ~ones_total(at);
      frame[at + 2] = s[15:8];
      frame[at + 3] = s[7:0];
   endtask

   // Builds a well-formed echo reply; hlen must be at least one.
   task automatic make_reply(input int hlen, input int payload_n, input logic [15:0] id);
      int at;
      frame.delete();
      frame.push_back({($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'h4, 4'(hlen)});
      for (int i = 1; i < 4 * hlen; i++) frame.push_back(8'($urandom_range(255)));
      at = 4 * hlen;
      frame.push_back(EchoReplyType);
      frame.push_back(GoodCode);
      frame.push_back(8'h00);
      frame.push_back(8'h00);
      frame.push_back(id[15:8]);
      frame.push_back(id[7:0]);
      for (int i = 0; i < payload_n + 2; i++) frame.push_back(8'($urandom_range(255)));
      seal_checksum(at);
   endtask

   task automatic random_packet();
      int unsigned pick;
      int unsigned hlen;
      int unsigned at;
      int unsigned idx;
      pick = $urandom_range(99);
      hlen = ($urandom_range(9) < 7) ? 5 : $urandom_range(15, 6);
      make_reply(hlen, ($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(24),
                 cur_id);
      at = 4 * hlen;
      if (pick < 60) begin
      end else if (pick < 65) begin
         frame[at] = ($urandom_range(1) == 0) ? 8'd8 : 8'($urandom_range(255, 1));
      end else if (pick < 70) begin
         frame[at + 1] = 8'($urandom_range(255, 1));
      end else if (pick < 75) begin
         frame[at + 4 + $urandom_range(1)] ^= 8'(1 << $urandom_range(7));
      end else if (pick < 82) begin
         idx = $urandom_range(frame.size() - 1, at + 2);
         if (idx == at + 4 || idx == at + 5) idx = at + 2;
         frame[idx] ^= 8'(1 << $urandom_range(7));
      end else if (pick < 87) begin
         trim_frame($urandom_range(at + 7, 20));
      end else if (pick < 91) begin
         make_reply($urandom_range(4, 1), $urandom_range(24), cur_id);
         if ($urandom_range(3) == 0) frame[0] = {frame[0][7:4], 4'h0};
      end else if (pick < 96) begin
         trim_frame($urandom_range(19, 1));
      end else begin
         frame.delete();
         repeat ($urandom_range(64, 1)) frame.push_back(8'($urandom_range(255)));
      end
      send_frame();
   endtask

   task automatic random_traffic(input int unsigned budget);
      int unsigned stop_at;
      stop_at = bytes_sent + budget;
      while (bytes_sent < stop_at) random_packet();
   endtask

   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_open != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_expected_id(input logic [15:0] v);
      wait_quiet();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= IdRegAddr;
      csr_pwdata <= {16'($urandom), v};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      cur_id = v;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed packets run first against the reset value of the identifier.
      frame = '{8'hFF};
      send_frame();
      make_reply(5, 0, cur_id);
      trim_frame(19);
      send_frame();
      make_reply(5, 4, cur_id);
      frame[0] = 8'h40;
      send_frame();
      make_reply(4, 12, cur_id);
      send_frame();
      make_reply(5, 0, cur_id);
      send_frame();
      make_reply(5, 0, cur_id);
      trim_frame(27);
      send_frame();
      make_reply(15, 0, cur_id);
      trim_frame(67);
      send_frame();
      make_reply(15, 3, cur_id);
      send_frame();
      make_reply(5, 2, cur_id);
      frame[20] = 8'hFF;
      send_frame();
      make_reply(5, 2, cur_id);
      frame[21] = 8'hFF;
      send_frame();
      make_reply(5, 2, 16'h8001);
      send_frame();
      make_reply(5, 5, cur_id);
      frame[22] ^= 8'h01;
      send_frame();
      make_reply(5, 16, cur_id);
      for (int i = 24; i < frame.size(); i++) frame[i] = 8'hFF;
      seal_checksum(20);
      send_frame();
      make_reply(5, 16, cur_id);
      for (int i = 24; i < frame.size(); i++) frame[i] = 8'h00;
      seal_checksum(20);
      send_frame();

      write_expected_id(16'hFFFF);
      make_reply(5, 1, 16'hFFFF);
      send_frame();
      make_reply(5, 1, 16'h0000);
      send_frame();
      random_traffic(300);

      write_expected_id(16'($urandom));
      send_idle_pct = 47;
      recv_idle_pct = 36;
      random_traffic(300);

      write_expected_id(16'($urandom));
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_go <= 1'b1;
      repeat (16) begin
         make_reply(5, 0, cur_id);
         trim_frame($urandom_range(3, 1));
         send_frame();
      end
      random_traffic(300);

      wait_quiet();
      repeat (10) @(posedge clock);
      $display("Sent %0d packets (%0d bytes) under three idling mixes and one long stall,",
               packets_sent, bytes_sent);
      $display("with good, damaged and short packets; %0d verdicts were compared.",
               verdicts_checked);
      if (fault_count == 0 && results_open == 0) begin
         $display("** icmp_echo_reply_check: PASSED **");
      end else begin
         $display("** icmp_echo_reply_check: FAILED **");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/icmp_erc_pkg.sv
sv/icmp_erc_csr.sv
sv/icmp_erc_core.sv
sv/icmp_erc_obuf.sv
sv/icmp_echo_reply_check.sv
dv/icmp_echo_reply_check_monitor.sv
dv/icmp_echo_reply_check_tb.sv
